### hdl/sfd_pkg.sv
package sfd_pkg;

  localparam int SIZE_LIMIT_DEF = 512;
  localparam int INDEX_W        = 9;

  localparam logic [7:0] START_BYTE = 8'hff;
  localparam logic [7:0] END_BYTE   = 8'h7f;
  localparam int         TAIL_BYTES = 2;

  localparam logic [7:0] ID_LIMIT_RESET = 8'd3;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_CHECK   = 2'd2,
    PH_END     = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_SUM_BAD = 2'd2,
    KIND_END_BAD = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [7:0]           frame_id;
    logic [7:0]           payload_byte;
    logic [INDEX_W-1:0]   payload_index;
    logic                 frame_last;
  } result_t;

endpackage

### hdl/serial_frame_deframer_unit.sv
// Serial frame deframer. Takes one received byte per item on the s_ side and
// hunts for a 4-byte header: start byte 0xff, a message id below the
// configured limit (cfg_wr_data, reset 3), and a little-endian 16-bit size
// with 2 <= size < SIZE_LIMIT, counting payload plus a 2-byte tail
// (mod-256 checksum of the payload, then end byte 0x7f). Hunting slides one
// byte at a time, so a header may start at any offset. Payload bytes leave on
// the m_ side with the frame id and their index; the frame closes with one
// status item (good, checksum mismatch, or bad end byte; a bad end byte wins
// when both faults are present), after which hunting restarts with an empty
// window. Hunted bytes, header bytes and the checksum byte give no output
// item. Throughput is one byte per clock while s_tready is high: all
// per-byte work is one pass of logic from the accepted byte into the output
// register (or into the skid slot while the output is held). A two-entry
// output stage (register plus skid slot) lets input continue while a result
// waits; s_tready drops only once both entries are held. Indices and lengths
// are reported modulo 512.
module serial_frame_deframer_unit #(
  parameter int SIZE_LIMIT = sfd_pkg::SIZE_LIMIT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,   // message_id_limit
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,       // [7:0] rx_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [31:0] m_tdata,      // [7:0] frame_id, [15:8] payload_byte,
                                    // [24:16] payload_index, [31:25] zero
  output logic [1:0] m_tuser,       // [1:0] kind
  output logic       m_tlast        // frame_last
);
  import sfd_pkg::*;

  localparam int LEN_W = $clog2(SIZE_LIMIT);

  // configuration
  logic [7:0] id_limit;

  // frame state
  logic [7:0]       win [3];
  logic [7:0]       win_next [3];
  logic [1:0]       fill, fill_next;
  phase_t           phase, phase_next;
  logic [7:0]       cur_id, cur_id_next;
  logic [LEN_W-1:0] pay_len, pay_len_next;
  logic [LEN_W-1:0] byte_pos, byte_pos_next;
  logic [7:0]       run_sum, run_sum_next;
  logic             sum_ok, sum_ok_next;

  logic             acc;
  logic [15:0]      size;
  logic             hdr_ok;
  logic [LEN_W-1:0] byte_pos_inc;

  logic    res_valid;
  logic    res_ready;
  result_t res;
  result_t out_item;

  assign acc          = s_tvalid && s_tready;
  assign s_tready     = res_ready;
  assign size         = {s_tdata, win[2]};
  assign byte_pos_inc = byte_pos + 1'b1;
  // a size of 0 or 1 would underflow the payload length, so it is rejected
  assign hdr_ok = (fill == 2'd3) && (win[0] == START_BYTE) && (win[1] < id_limit)
               && (size >= 16'(TAIL_BYTES)) && (size < 16'(SIZE_LIMIT));

  // next state
  always_comb begin
    win_next      = win;
    fill_next     = fill;
    phase_next    = phase;
    cur_id_next   = cur_id;
    pay_len_next  = pay_len;
    byte_pos_next = byte_pos;
    run_sum_next  = run_sum;
    sum_ok_next   = sum_ok;
    if (acc) begin
      unique case (phase)
        PH_HUNT: begin
          if (fill != 2'd3) begin
            win_next[fill] = s_tdata;
            fill_next      = fill + 2'd1;
          end else if (hdr_ok) begin
            cur_id_next   = win[1];
            pay_len_next  = LEN_W'(size - 16'(TAIL_BYTES));
            byte_pos_next = '0;
            run_sum_next  = '0;
            sum_ok_next   = 1'b0;
            fill_next     = 2'd0;
            // empty payload goes straight to the checksum byte
            phase_next    = (size == 16'(TAIL_BYTES)) ? PH_CHECK : PH_PAYLOAD;
          end else begin
            win_next[0] = win[1];
            win_next[1] = win[2];
            win_next[2] = s_tdata;
          end
        end
        PH_PAYLOAD: begin
          run_sum_next  = run_sum + s_tdata;
          byte_pos_next = byte_pos_inc;
          if (byte_pos_inc >= pay_len) begin
            phase_next = PH_CHECK;
          end
        end
        PH_CHECK: begin
          sum_ok_next = (s_tdata == run_sum);
          phase_next  = PH_END;
        end
        PH_END: begin
          phase_next = PH_HUNT;
          fill_next  = 2'd0;
        end
      endcase
    end
  end

  // result for the byte being accepted
  always_comb begin
    res_valid         = 1'b0;
    res.kind          = KIND_PAYLOAD;
    res.frame_id      = cur_id;
    res.payload_byte  = 8'd0;
    res.payload_index = INDEX_W'(pay_len);
    res.frame_last    = 1'b0;
    unique case (phase)
      PH_PAYLOAD: begin
        res_valid         = acc;
        res.payload_byte  = s_tdata;
        res.payload_index = INDEX_W'(byte_pos);
      end
      PH_END: begin
        res_valid      = acc;
        res.frame_last = 1'b1;
        priority if (s_tdata != END_BYTE) begin
          res.kind = KIND_END_BAD;
        end else if (!sum_ok) begin
          res.kind = KIND_SUM_BAD;
        end else begin
          res.kind = KIND_GOOD;
        end
      end
      PH_HUNT, PH_CHECK: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      id_limit <= ID_LIMIT_RESET;
      phase    <= PH_HUNT;
      fill     <= 2'd0;
      win[0]   <= '0;
      win[1]   <= '0;
      win[2]   <= '0;
      cur_id   <= '0;
      pay_len  <= '0;
      byte_pos <= '0;
      run_sum  <= '0;
      sum_ok   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        id_limit <= cfg_wr_data;
      end
      phase    <= phase_next;
      fill     <= fill_next;
      win      <= win_next;
      cur_id   <= cur_id_next;
      pay_len  <= pay_len_next;
      byte_pos <= byte_pos_next;
      run_sum  <= run_sum_next;
      sum_ok   <= sum_ok_next;
    end
  end

  sfd_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_ready  (res_ready),
    .in_item   (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (out_item)
  );

  assign m_tdata = {7'd0, out_item.payload_index, out_item.payload_byte, out_item.frame_id};
  assign m_tuser = out_item.kind;
  assign m_tlast = out_item.frame_last;

  // input stalls only when both output entries are occupied
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with empty output register");

  // payload index always stays below the frame's payload length
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> byte_pos < pay_len)
    else $error("payload position out of range");

  // hunted, header and checksum bytes never produce an item
  a_no_hunt_out: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HUNT || phase == PH_CHECK) |-> !res_valid)
    else $error("result produced outside payload or end phase");

  // a frame-ending status is followed by a fresh hunt with an empty window
  a_end_restart: assert property (@(posedge clk) disable iff (rst)
    acc && phase == PH_END |=> phase == PH_HUNT && fill == 2'd0)
    else $error("no restart after frame end");

endmodule

### hdl/sfd_out_skid.sv
// Two-entry output stage: output register plus one skid slot.
module sfd_out_skid (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  sfd_pkg::result_t in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output sfd_pkg::result_t out_item
);
  import sfd_pkg::*;

  logic    skid_valid;
  result_t skid_item;

  // Space is guaranteed while the skid slot is empty.
  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_item   <= skid_item;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
        out_item  <= in_item;
      end
    end else if (in_valid) begin
      skid_valid <= 1'b1;
      skid_item  <= in_item;
    end
  end

endmodule
